[src/rpat_pkg.sv]
// Shared constants, state encoding and interface types of the radius point association table.
package rpat_pkg;

  // Fixed field widths of the ports
  localparam int POS_W    = 20;
  localparam int ID_W     = 6;
  localparam int COUNT_W  = 16;
  localparam int RADIUS_W = 44;

  // Defaults for the top-level parameters
  localparam int MAX_SPOTS_DEF  = 64;
  localparam int COORD_BITS_DEF = 20;

  // 0.5 squared in Q.20
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 44'd262144;
  localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT,
    ST_DONE
  } rpat_state_t;

  // Per-entry outcome of the distance unit
  typedef struct packed {
    logic valid;
    logic hit;
  } rpat_dist_res_t;

endpackage

[src/rpat_ram.sv]
// Simple dual-port RAM: one write port, one read port with registered read data.
module rpat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, data held until the next enabled read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/rpat_dist_unit.sv]
// Pipelined squared-distance and radius compare unit, one table entry per cycle.
module rpat_dist_unit #(
  parameter int COORD_BITS = rpat_pkg::COORD_BITS_DEF,
  parameter int IDX_W      = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          flush,
  input  logic                          in_valid,
  input  logic [IDX_W-1:0]              in_idx,
  input  logic [3*COORD_BITS-1:0]       centre,
  input  logic [3*COORD_BITS-1:0]       point,
  input  logic [rpat_pkg::RADIUS_W-1:0] radius,
  output rpat_pkg::rpat_dist_res_t      res,
  output logic [IDX_W-1:0]              res_idx
);
  import rpat_pkg::*;

  localparam int D_W   = COORD_BITS + 1;
  localparam int SQ_W  = 2 * D_W;
  localparam int SUM_W = SQ_W;

  logic [D_W-1:0]   abs_nxt [3];
  logic [D_W-1:0]   abs_r   [3];
  logic [SQ_W-1:0]  sq_nxt  [3];
  logic [SQ_W-1:0]  sq_r    [3];
  logic [SUM_W-1:0] sum;
  logic             hit_nxt;

  logic             v1_r, v2_r, v3_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r;
  logic             hit3_r;

  // stage 1: per-axis difference and magnitude
  always_comb begin
    logic [D_W-1:0] c_ext;
    logic [D_W-1:0] p_ext;
    logic [D_W-1:0] diff;
    for (int k = 0; k < 3; k++) begin
      c_ext      = {centre[k*COORD_BITS + COORD_BITS - 1],
                    centre[k*COORD_BITS +: COORD_BITS]};
      p_ext      = {point[k*COORD_BITS + COORD_BITS - 1],
                    point[k*COORD_BITS +: COORD_BITS]};
      diff       = c_ext - p_ext;
      abs_nxt[k] = diff[D_W-1] ? (~diff + D_W'(1)) : diff;
    end
  end

  // stage 2: squares
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_nxt[k] = abs_r[k] * abs_r[k];
    end
  end

  // stage 3: sum and strict compare against the radius
  assign sum     = sq_r[0] + sq_r[1] + sq_r[2];
  assign hit_nxt = RADIUS_W'(sum) < radius;

  // datapath registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      abs_r[k] <= abs_nxt[k];
      sq_r[k]  <= sq_nxt[k];
    end
    idx1_r <= in_idx;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    hit3_r <= hit_nxt;
  end

  // valid tags, dropped when the scan stops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid & ~flush;
      v2_r <= v1_r & ~flush;
      v3_r <= v2_r & ~flush;
    end
  end

  assign res.valid = v3_r;
  assign res.hit   = hit3_r;
  assign res_idx   = idx3_r;

endmodule

[src/radius_point_association_table.sv]
// Top level: spot table, scan sequencer and result register.
//
// Usage:
//   Input channel in_valid/in_stall carries one 3-D point (in_pos_x/y/z, signed
//   Q10.10, low COORD_BITS bits used). The point is compared in index order with
//   every stored spot centre; the first centre whose squared distance is below
//   the radius register wins and its hit count rises (saturating).
//   Otherwise the point becomes a new spot, or table_full is reported when all
//   MAX_SPOTS entries are in use. Each point gives exactly one result on
//   out_valid/out_stall.
//   Configuration: cfg_valid/cfg_ready writes the squared radius; cfg_ready is
//   always high. Write it only while no point is in flight.
// Timing:
//   The scan issues one centre read per cycle into the distance pipeline. A
//   miss scans all n spots in use, a match ends the scan at the first hit, and
//   an empty table skips the scan; one point at a time.
//   in_stall is high from acceptance until the result is loaded.
// Reset: synchronous; the spot count clears to zero and the radius returns to
//   0.5 squared. Table contents need no clearing pass.
// Stall: a finished result waits in the output register; the block can take the
//   next point meanwhile, but holds that point's result until the register frees.
module radius_point_association_table #(
  parameter int MAX_SPOTS  = rpat_pkg::MAX_SPOTS_DEF,
  parameter int COORD_BITS = rpat_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // point requests
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [rpat_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [rpat_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [rpat_pkg::POS_W-1:0]   in_pos_z,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rpat_pkg::ID_W-1:0]           out_spot_id,
  output logic                                out_created,
  output logic                                out_table_full,
  output logic [rpat_pkg::COUNT_W-1:0]        out_hit_count,
  // radius register write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rpat_pkg::RADIUS_W-1:0]       cfg_radius_squared
);
  import rpat_pkg::*;

  localparam int IDX_W = $clog2(MAX_SPOTS);
  localparam int CNT_W = $clog2(MAX_SPOTS + 1);
  localparam int PT_W  = 3 * COORD_BITS;

  rpat_state_t          state_r, state_nxt;
  logic [RADIUS_W-1:0]  radius_r;
  logic [PT_W-1:0]      point_r;
  logic [CNT_W-1:0]     spots_r;
  logic [CNT_W-1:0]     issue_r;
  logic                 rd_valid_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 match_r;
  logic [IDX_W-1:0]     hit_idx_r;

  logic                 out_valid_r;
  logic [ID_W-1:0]      out_spot_id_r;
  logic                 out_created_r;
  logic                 out_full_r;
  logic [COUNT_W-1:0]   out_count_r;

  logic                 accept_in;
  logic                 out_free;
  logic                 issue;
  logic                 count_re;
  logic                 load_out;
  logic                 centre_we;
  logic                 count_we;
  logic                 last_res;
  logic                 full;
  logic [IDX_W-1:0]     new_idx;
  logic [IDX_W-1:0]     id_idx;
  logic [IDX_W+ID_W-1:0] id_wide;
  logic [IDX_W-1:0]     count_waddr;
  logic [COUNT_W-1:0]   count_wdata;
  logic [COUNT_W-1:0]   count_rd;
  logic [COUNT_W-1:0]   next_count;
  logic [PT_W-1:0]      centre_rd;

  rpat_dist_res_t       res;
  logic [IDX_W-1:0]     res_idx;

  // table status
  assign full       = spots_r == CNT_W'(MAX_SPOTS);
  assign new_idx    = spots_r[IDX_W-1:0];
  assign last_res   = (CNT_W'(res_idx) + CNT_W'(1)) == spots_r;
  assign next_count = (count_rd == COUNT_MAX) ? count_rd : count_rd + COUNT_W'(1);
  assign out_free   = !out_valid_r || !out_stall;
  assign accept_in  = in_valid && !in_stall;

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (spots_r == '0) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (res.valid && res.hit) begin
          state_nxt = ST_COUNT;
        end else if (res.valid && last_res) begin
          state_nxt = ST_DONE;
        end
      end
      ST_COUNT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: control outputs
  always_comb begin
    in_stall  = (state_r != ST_IDLE);
    issue     = (state_r == ST_SCAN) && (issue_r < spots_r);
    count_re  = (state_r == ST_COUNT);
    load_out  = (state_r == ST_DONE) && out_free;
    centre_we = load_out && !match_r && !full;
    count_we  = load_out && (match_r || !full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // radius register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_radius_squared;
    end
  end

  // scan control and spot count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spots_r    <= '0;
      issue_r    <= '0;
      rd_valid_r <= 1'b0;
      match_r    <= 1'b0;
    end else begin
      rd_valid_r <= issue;
      if (accept_in) begin
        issue_r <= '0;
        match_r <= 1'b0;
      end else if (issue) begin
        issue_r <= issue_r + CNT_W'(1);
      end
      if (state_r == ST_SCAN && res.valid && res.hit) begin
        match_r <= 1'b1;
      end
      if (centre_we) begin
        spots_r <= spots_r + CNT_W'(1);
      end
    end
  end

  // point and scan payload
  always_ff @(posedge clk) begin
    rd_idx_r <= issue_r[IDX_W-1:0];
    if (accept_in) begin
      point_r <= {in_pos_x[COORD_BITS-1:0], in_pos_y[COORD_BITS-1:0],
                  in_pos_z[COORD_BITS-1:0]};
    end
    if (state_r == ST_SCAN && res.valid && res.hit) begin
      hit_idx_r <= res_idx;
    end
  end

  // centre storage
  rpat_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_SPOTS)
  ) u_centre_ram (
    .clk   (clk),
    .we    (centre_we),
    .waddr (new_idx),
    .wdata (point_r),
    .re    (issue),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (centre_rd)
  );

  // observation counts: read-modify-write on a match, 1 on a new spot
  assign count_waddr = match_r ? hit_idx_r : new_idx;
  assign count_wdata = match_r ? next_count : COUNT_W'(1);

  rpat_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_SPOTS)
  ) u_count_ram (
    .clk   (clk),
    .we    (count_we),
    .waddr (count_waddr),
    .wdata (count_wdata),
    .re    (count_re),
    .raddr (hit_idx_r),
    .rdata (count_rd)
  );

  // shared distance unit
  rpat_dist_unit #(
    .COORD_BITS (COORD_BITS),
    .IDX_W      (IDX_W)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .flush    (state_r != ST_SCAN),
    .in_valid (rd_valid_r),
    .in_idx   (rd_idx_r),
    .centre   (centre_rd),
    .point    (point_r),
    .radius   (radius_r),
    .res      (res),
    .res_idx  (res_idx)
  );

  // result register
  assign id_idx  = match_r ? hit_idx_r : (full ? '0 : new_idx);
  assign id_wide = {{ID_W{1'b0}}, id_idx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_spot_id_r <= id_wide[ID_W-1:0];
      out_created_r <= !match_r && !full;
      out_full_r    <= !match_r && full;
      out_count_r   <= match_r ? next_count : (full ? '0 : COUNT_W'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_spot_id    = out_spot_id_r;
  assign out_created    = out_created_r;
  assign out_table_full = out_full_r;
  assign out_hit_count  = out_count_r;

endmodule

[src/rpat_checker.sv]
// Port-level checker of the radius point association table and its bind.
module rpat_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rpat_pkg::ID_W-1:0]    out_spot_id,
  input logic                         out_created,
  input logic                         out_table_full,
  input logic [rpat_pkg::COUNT_W-1:0] out_hit_count
);
  import rpat_pkg::*;

  // a point in work keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a request was accepted");

  // a dropped point reports no spot and no count
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |->
      !out_created && out_spot_id == '0 && out_hit_count == '0)
    else $error("table_full result with spot fields set");

  // a new spot starts at one observation
  a_created_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_created |-> out_hit_count == COUNT_W'(1))
    else $error("created spot with count other than one");

  // a matched spot has been seen at least twice
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_created && !out_table_full |-> out_hit_count > COUNT_W'(1))
    else $error("matched spot with count below two");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_spot_id) &&
      $stable(out_hit_count) && $stable(out_created) && $stable(out_table_full))
    else $error("stalled result changed");

endmodule

bind radius_point_association_table rpat_checker u_rpat_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_spot_id    (out_spot_id),
  .out_created    (out_created),
  .out_table_full (out_table_full),
  .out_hit_count  (out_hit_count)
);
